// ===== design/lmpc_pkg.sv =====
package lmpc_pkg;

   localparam int MAX_CHARS = 7;
   localparam int LEN_BITS  = 3;
   localparam int IDX_BITS  = 10;
   localparam int CNT_BITS  = 32;

   localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_CHAR = 2'd1,
      OP_EOL  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_STORED = 2'd0,
      STAT_DUP    = 2'd1,
      STAT_REJECT = 2'd2,
      STAT_COUNT  = 2'd3
   } status_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [LEN_BITS-1:0] len;
      logic [IDX_BITS-1:0] idx;
   } head_type;

endpackage

// ===== design/longest_match_phrase_counter.sv =====
// Dictionary longest-match phrase counter. Load phrases (action 0), stream
// article characters (1) and line ends (2), and read per-slot counts (3).
// Loads and reads return one result item each; characters and line ends
// return none. Items enter a two-entry queue; the engine behind it takes one
// item at a time and scans the dictionary RAM one slot per cycle, so used, the
// number of stored phrases, sets the cost. An empty load is rejected without a
// scan; other loads scan all phrases, then store, reject if full, or read a
// duplicate's count. A read reads a loaded slot's count, else answers zero. A
// character that fills the window starts a scan and shift, with a count update
// on a match; others only enter the window. A line end after two or more
// characters scans once per character left; it always empties the window. The
// engine takes no new item while a result item waits to be accepted.
module longest_match_phrase_counter
   import lmpc_pkg::*;
#(
   parameter int DICT_ENTRIES = 1024,
   parameter int CHAR_BITS    = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [LEN_BITS-1:0]  req_entry_length,
   input  logic [CHAR_BITS-1:0] req_char_0,
   input  logic [CHAR_BITS-1:0] req_char_1,
   input  logic [CHAR_BITS-1:0] req_char_2,
   input  logic [CHAR_BITS-1:0] req_char_3,
   input  logic [CHAR_BITS-1:0] req_char_4,
   input  logic [CHAR_BITS-1:0] req_char_5,
   input  logic [CHAR_BITS-1:0] req_char_6,
   input  logic [IDX_BITS-1:0]  req_entry_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [IDX_BITS-1:0]  rsp_slot,
   output logic [CNT_BITS-1:0]  rsp_hit_count
);

   head_type                       head;
   logic [MAX_CHARS*CHAR_BITS-1:0] head_chars;
   logic                           pop;

   lmpc_front #(.CHAR_BITS(CHAR_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_entry_length (req_entry_length),
      .req_chars        ({req_char_6, req_char_5, req_char_4, req_char_3,
                          req_char_2, req_char_1, req_char_0}),
      .req_entry_index  (req_entry_index),
      .head             (head),
      .head_chars       (head_chars),
      .pop              (pop)
   );

   lmpc_back #(.DICT_ENTRIES(DICT_ENTRIES), .CHAR_BITS(CHAR_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_chars    (head_chars),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule

// ===== design/lmpc_ram.sv =====
module lmpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/lmpc_front.sv =====
module lmpc_front
   import lmpc_pkg::*;
#(
   parameter int CHAR_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic [LEN_BITS-1:0]            req_entry_length,
   input  logic [MAX_CHARS*CHAR_BITS-1:0] req_chars,
   input  logic [IDX_BITS-1:0]            req_entry_index,
   output head_type                       head,
   output logic [MAX_CHARS*CHAR_BITS-1:0] head_chars,
   input  logic                           pop
);

   // Two-entry queue between the port and the dictionary engine.
   head_type                       meta_ff  [2];
   logic [MAX_CHARS*CHAR_BITS-1:0] chars_ff [2];
   logic                           wr_ptr_ff;
   logic                           rd_ptr_ff;
   logic [1:0]                     count_ff;
   logic                           push;
   logic                           do_pop;
   head_type                       entry;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   always_comb begin
      entry       = '0;
      entry.valid = 1'b1;
      entry.op    = op_type'(req_action);
      entry.len   = req_entry_length;
      entry.idx   = req_entry_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            meta_ff[wr_ptr_ff]  <= entry;
            chars_ff[wr_ptr_ff] <= req_chars;
            wr_ptr_ff           <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(do_pop);
      end
   end

   always_comb begin
      head       = meta_ff[rd_ptr_ff];
      head.valid = (count_ff != 2'd0);
      head_chars = chars_ff[rd_ptr_ff];
   end

endmodule

// ===== design/lmpc_back.sv =====
module lmpc_back
   import lmpc_pkg::*;
#(
   parameter int DICT_ENTRIES = 1024,
   parameter int CHAR_BITS    = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  head_type                       head,
   input  logic [MAX_CHARS*CHAR_BITS-1:0] head_chars,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [IDX_BITS-1:0]            rsp_slot,
   output logic [CNT_BITS-1:0]            rsp_hit_count
);

   localparam int SA = $clog2(DICT_ENTRIES);
   localparam int UW = $clog2(DICT_ENTRIES + 1);
   localparam int EW = LEN_BITS + MAX_CHARS * CHAR_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_RESOLVE, S_CNT_RD, S_CNT_USE, S_SHIFT
   } state_type;

   state_type                      state_ff;
   op_type                         op_ff;
   logic [LEN_BITS-1:0]            len_ff;
   logic [IDX_BITS-1:0]            idx_ff;
   logic [MAX_CHARS*CHAR_BITS-1:0] key_ff;
   logic [CHAR_BITS-1:0]           win_ff [MAX_CHARS];
   logic [LEN_BITS-1:0]            fill_ff;
   logic [1:0]                     seen_ff;
   logic [UW-1:0]                  used_ff;
   logic [UW-1:0]                  s_ff;
   logic                           chk_ff;
   logic [SA-1:0]                  chk_slot_ff;
   logic [LEN_BITS-1:0]            best_len_ff;
   logic [SA-1:0]                  best_slot_ff;
   logic [SA-1:0]                  cnt_addr_ff;
   logic                           rsp_valid_ff;
   status_type                     rsp_status_ff;
   logic [IDX_BITS-1:0]            rsp_slot_ff;
   logic [CNT_BITS-1:0]            rsp_count_ff;

   logic [EW-1:0]       ent_rdata;
   logic                ent_we;
   logic [CNT_BITS-1:0] cnt_rdata;
   logic                cnt_we;
   logic [SA-1:0]       cnt_waddr;
   logic [CNT_BITS-1:0] cnt_wdata;
   logic [LEN_BITS-1:0] e_len;
   logic [LEN_BITS-1:0] lo;
   logic [LEN_BITS-1:0] hi;
   logic [CHAR_BITS-1:0] kc;
   logic                prefix_ok;
   logic                hit;
   logic                found;
   logic                full;
   logic                win_op;

   assign found  = (best_len_ff != '0);
   assign full   = (used_ff == UW'(DICT_ENTRIES));
   assign win_op = (op_ff == OP_CHAR) || (op_ff == OP_EOL);
   assign pop    = (state_ff == S_IDLE) && head.valid && !rsp_valid_ff;

   // Accepted phrase lengths: exact for a load, 2 to fill (or 1 for a
   // single character left) for an article position.
   always_comb begin
      if (op_ff == OP_LOAD) begin
         lo = len_ff;
         hi = len_ff;
      end else begin
         hi = fill_ff;
         lo = (fill_ff >= LEN_BITS'(2)) ? LEN_BITS'(2) : LEN_BITS'(1);
      end
   end

   always_comb begin
      e_len     = ent_rdata[LEN_BITS-1:0];
      prefix_ok = 1'b1;
      kc        = '0;
      for (int k = 0; k < MAX_CHARS; k++) begin
         kc = (op_ff == OP_LOAD) ? key_ff[k*CHAR_BITS +: CHAR_BITS] : win_ff[k];
         if ((k < int'(e_len)) && (ent_rdata[LEN_BITS + k*CHAR_BITS +: CHAR_BITS] != kc)) begin
            prefix_ok = 1'b0;
         end
      end
      hit = chk_ff && prefix_ok && (e_len >= lo) && (e_len <= hi) && (e_len > best_len_ff);
   end

   assign ent_we    = (state_ff == S_RESOLVE) && (op_ff == OP_LOAD) && !found && !full;
   assign cnt_we    = ent_we || ((state_ff == S_CNT_USE) && win_op);
   assign cnt_waddr = ent_we ? used_ff[SA-1:0] : cnt_addr_ff;
   assign cnt_wdata = ent_we ? '0 :
                      ((cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1);

   lmpc_ram #(.WIDTH(EW), .DEPTH(DICT_ENTRIES)) u_entries (
      .clock (clock),
      .we    (ent_we),
      .waddr (used_ff[SA-1:0]),
      .wdata ({key_ff, len_ff}),
      .raddr (s_ff[SA-1:0]),
      .rdata (ent_rdata)
   );

   lmpc_ram #(.WIDTH(CNT_BITS), .DEPTH(DICT_ENTRIES)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_addr_ff),
      .rdata (cnt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         seen_ff      <= '0;
         used_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_CHARS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (hit) begin
            best_len_ff  <= e_len;
            best_slot_ff <= chk_slot_ff;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  op_ff       <= head.op;
                  len_ff      <= head.len;
                  idx_ff      <= head.idx;
                  key_ff      <= head_chars;
                  s_ff        <= '0;
                  best_len_ff <= '0;
                  unique case (head.op)
                     OP_LOAD: begin
                        if (head.len == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STAT_REJECT;
                           rsp_slot_ff   <= '0;
                           rsp_count_ff  <= '0;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     OP_CHAR: begin
                        win_ff[fill_ff] <= head_chars[CHAR_BITS-1:0];
                        fill_ff         <= fill_ff + 1'b1;
                        if (seen_ff != 2'd2) begin
                           seen_ff <= seen_ff + 1'b1;
                        end
                        if (fill_ff == LEN_BITS'(MAX_CHARS - 1)) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     OP_EOL: begin
                        if ((seen_ff == 2'd2) && (fill_ff != '0)) begin
                           state_ff <= S_SCAN;
                        end else begin
                           fill_ff <= '0;
                           seen_ff <= '0;
                           for (int k = 0; k < MAX_CHARS; k++) begin
                              win_ff[k] <= '0;
                           end
                        end
                     end
                     OP_READ: begin
                        if (32'(head.idx) < 32'(used_ff)) begin
                           cnt_addr_ff <= SA'(head.idx);
                           state_ff    <= S_CNT_RD;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STAT_COUNT;
                           rsp_slot_ff   <= head.idx;
                           rsp_count_ff  <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               // One slot read per cycle; the compare lands in the next cycle.
               chk_ff <= (s_ff != used_ff);
               if (s_ff != used_ff) begin
                  chk_slot_ff <= s_ff[SA-1:0];
                  s_ff        <= s_ff + 1'b1;
               end else begin
                  state_ff <= S_RESOLVE;
               end
            end
            S_RESOLVE: begin
               if (found) begin
                  cnt_addr_ff <= best_slot_ff;
                  state_ff    <= S_CNT_RD;
               end else if (op_ff == OP_LOAD) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= '0;
                  state_ff     <= S_IDLE;
                  if (full) begin
                     rsp_status_ff <= STAT_REJECT;
                     rsp_slot_ff   <= '0;
                  end else begin
                     rsp_status_ff <= STAT_STORED;
                     rsp_slot_ff   <= IDX_BITS'(used_ff);
                     used_ff       <= used_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_SHIFT;
               end
            end
            S_CNT_RD: begin
               state_ff <= S_CNT_USE;
            end
            S_CNT_USE: begin
               if (win_op) begin
                  state_ff <= S_SHIFT;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= (op_ff == OP_LOAD) ? STAT_DUP : STAT_COUNT;
                  rsp_slot_ff   <= (op_ff == OP_LOAD) ? IDX_BITS'(best_slot_ff) : idx_ff;
                  rsp_count_ff  <= cnt_rdata;
                  state_ff      <= S_IDLE;
               end
            end
            S_SHIFT: begin
               for (int k = 1; k < MAX_CHARS; k++) begin
                  win_ff[k-1] <= win_ff[k];
               end
               win_ff[MAX_CHARS-1] <= '0;
               fill_ff             <= fill_ff - 1'b1;
               s_ff                <= '0;
               best_len_ff         <= '0;
               if ((op_ff == OP_EOL) && (fill_ff != LEN_BITS'(1))) begin
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_IDLE;
                  if (op_ff == OP_EOL) begin
                     seen_ff <= '0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_hit_count = rsp_count_ff;

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while an item is in progress");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= DICT_ENTRIES)
      else $error("entry count beyond dictionary size");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && (s_ff == used_ff)) |=> (state_ff == S_RESOLVE))
      else $error("scan did not resolve after the last slot");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_CHARS)
      else $error("window overfilled");

endmodule
